// ===== hw/rtl/spbc_pkg.sv =====
package spbc_pkg;

  localparam int StepW = 5;

  // 2*pi in Q3.29, and the reciprocal of 1000 scaled by 2^49
  localparam logic [31:0] TwoPiQ29 = 32'd3373259426;
  localparam logic [39:0] DivRecip = 40'((64'd1 << 49) / 64'd1000);

  localparam logic signed [47:0] Sat47      = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [31:0] OneQ16     = 32'sd65536;
  localparam logic signed [31:0] RevThresh  = 32'sd26214400;  // 400.0 in Q16.16
  localparam logic signed [31:0] CtrlThresh = 32'sd32768000;  // 500.0 in Q16.16
  localparam logic [15:0]        CntMax     = 16'hFFFF;
  localparam logic [10:0]        DivBy      = 11'd1000;
  localparam logic [48:0]        RoundHalf  = 49'd500;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_BACKCALC_GAIN = 3'd2,
    REG_OUTPUT_LIMIT  = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef enum logic [1:0] {
    MA_REF,
    MA_MAG_LO,
    MA_MAG_HI
  } mula_t;

  typedef enum logic [2:0] {
    MB_TWOPI_LO,
    MB_TWOPI_HI,
    MB_KP,
    MB_KB,
    MB_KI,
    MB_RECIP_LO,
    MB_RECIP_HI
  } mulb_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD24,
    ACC_ADD32,
    ACC_ADD56
  } acc_op_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ROUND,
    ALU_PEN,
    ALU_SUM,
    ALU_UNC,
    ALU_CLAMP,
    ALU_DIFF,
    ALU_BC,
    ALU_KI,
    ALU_DIVPREP,
    ALU_QUOT,
    ALU_FIX,
    ALU_INTEG
  } alu_op_t;

  typedef enum logic [1:0] {
    NX_NEXT,
    NX_SKIP_PEN,
    NX_WAIT_OUT,
    NX_END
  } next_t;

  typedef struct packed {
    mula_t            mul_a;
    mulb_t            mul_b;
    acc_op_t          acc;
    alu_op_t          alu;
    next_t            nx;
    logic [StepW-1:0] target;
  } uword_t;

  localparam logic [StepW-1:0] StepSum = 5'd5;

  localparam uword_t UopNop = '{
    mul_a:  MA_REF,
    mul_b:  MB_KP,
    acc:    ACC_HOLD,
    alu:    ALU_NOP,
    nx:     NX_NEXT,
    target: '0
  };

  function automatic logic signed [47:0] sat47(input logic signed [48:0] v);
    logic signed [48:0] lim;
    lim = $signed({1'b0, Sat47});
    if (v > lim) begin
      sat47 = Sat47;
    end else if (v < -lim) begin
      sat47 = -Sat47;
    end else begin
      sat47 = v[47:0];
    end
  endfunction

  function automatic logic [48:0] mag49(input logic signed [48:0] v);
    mag49 = v[48] ? 49'(-v) : 49'(v);
  endfunction

  // Control store: one word per step. The multiplier result is registered in the
  // product register, where the accumulator field of the next step's word picks it up.
  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w = UopNop;
    case (step)
      5'd0: begin
        w.mul_a = MA_REF;
        w.mul_b = MB_TWOPI_LO;
      end
      5'd1: begin
        w.mul_a = MA_REF;
        w.mul_b = MB_TWOPI_HI;
        w.acc   = ACC_LOAD;
      end
      5'd2: w.acc = ACC_ADD24;
      5'd3: begin
        w.alu    = ALU_ROUND;
        w.nx     = NX_SKIP_PEN;
        w.target = StepSum;
      end
      5'd4: w.alu = ALU_PEN;
      5'd5: w.alu = ALU_SUM;
      5'd6: begin
        w.mul_a = MA_MAG_LO;
        w.mul_b = MB_KP;
      end
      5'd7: begin
        w.mul_a = MA_MAG_HI;
        w.mul_b = MB_KP;
        w.acc   = ACC_LOAD;
      end
      5'd8: w.acc = ACC_ADD32;
      5'd9: w.alu = ALU_UNC;
      5'd10: begin
        w.alu = ALU_CLAMP;
        w.nx  = NX_WAIT_OUT;
      end
      5'd11: w.alu = ALU_DIFF;
      5'd12: begin
        w.mul_a = MA_MAG_LO;
        w.mul_b = MB_KB;
      end
      5'd13: begin
        w.mul_a = MA_MAG_HI;
        w.mul_b = MB_KB;
        w.acc   = ACC_LOAD;
      end
      5'd14: w.acc = ACC_ADD32;
      5'd15: w.alu = ALU_BC;
      5'd16: begin
        w.mul_a = MA_MAG_LO;
        w.mul_b = MB_KI;
      end
      5'd17: begin
        w.mul_a = MA_MAG_HI;
        w.mul_b = MB_KI;
        w.acc   = ACC_LOAD;
      end
      5'd18: w.acc = ACC_ADD32;
      5'd19: w.alu = ALU_KI;
      5'd20: w.alu = ALU_DIVPREP;
      5'd21: begin
        w.mul_a = MA_MAG_LO;
        w.mul_b = MB_RECIP_LO;
      end
      5'd22: begin
        w.mul_a = MA_MAG_LO;
        w.mul_b = MB_RECIP_HI;
        w.acc   = ACC_LOAD;
      end
      5'd23: begin
        w.mul_a = MA_MAG_HI;
        w.mul_b = MB_RECIP_LO;
        w.acc   = ACC_ADD24;
      end
      5'd24: begin
        w.mul_a = MA_MAG_HI;
        w.mul_b = MB_RECIP_HI;
        w.acc   = ACC_ADD32;
      end
      5'd25: w.acc = ACC_ADD56;
      5'd26: w.alu = ALU_QUOT;
      5'd27: w.alu = ALU_FIX;
      5'd28: begin
        w.alu = ALU_INTEG;
        w.nx  = NX_END;
      end
      default: w.nx = NX_END;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/spbc_datapath.sv =====
module spbc_datapath
  import spbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [31:0] ref_speed_hz,
  input  logic signed [31:0] feedback_rad_s,
  input  logic [23:0]        prop_gain,
  input  logic [23:0]        integ_gain,
  input  logic [23:0]        backcalc_gain,
  input  logic [30:0]        output_limit,
  input  uword_t             ctl,
  output logic               no_pen,
  output logic signed [31:0] clamp_drive,
  output clamp_t             clamp_code
);

  logic signed [31:0] ref_r;
  logic signed [31:0] fb_r;
  logic [48:0]        mag_r;
  logic               neg_r;
  logic signed [47:0] err_r;
  logic signed [47:0] unc_r;
  logic signed [31:0] drive_r;
  logic signed [48:0] inc_r;
  logic [39:0]        q_r;
  logic [15:0]        pen_cnt_r;
  logic               pen_sub_r;
  logic [55:0]        prod_r;
  logic [88:0]        acc_r;
  logic [88:0]        acc_nxt;
  logic signed [47:0] integ_r;
  logic signed [47:0] integ_nxt;
  logic [15:0]        cnt_r;
  logic [15:0]        cnt_nxt;

  logic [31:0]        ref_mag;
  logic [31:0]        op_a;
  logic [23:0]        op_b;
  logic               rev_fwd;
  logic               rev_bwd;
  logic               fb_big;
  logic [15:0]        cnt_inc;
  logic signed [64:0] prod_signed;
  logic signed [64:0] prod_rnd;
  logic signed [47:0] err_round;
  logic [22:0]        pen_x100;
  logic signed [47:0] pen_amt;
  logic signed [47:0] err_pen;
  logic signed [47:0] sum_sat;
  logic [54:0]        gain_raw;
  logic [46:0]        gain_mag;
  logic signed [47:0] gain_term;
  logic signed [47:0] lim48;
  logic signed [47:0] drive48;
  logic signed [47:0] diff_sat;
  logic [10:0]        q_x1000;
  logic [10:0]        rem;
  logic signed [48:0] q_signed;

  always_comb begin
    ref_mag = ref_r[31] ? (~ref_r + 32'd1) : ref_r;

    case (ctl.mul_a)
      MA_REF:    op_a = ref_mag;
      MA_MAG_LO: op_a = mag_r[31:0];
      MA_MAG_HI: op_a = {15'b0, mag_r[48:32]};
      default:   op_a = '0;
    endcase

    case (ctl.mul_b)
      MB_TWOPI_LO: op_b = TwoPiQ29[23:0];
      MB_TWOPI_HI: op_b = {16'b0, TwoPiQ29[31:24]};
      MB_KP:       op_b = prop_gain;
      MB_KB:       op_b = backcalc_gain;
      MB_KI:       op_b = integ_gain;
      MB_RECIP_LO: op_b = DivRecip[23:0];
      MB_RECIP_HI: op_b = {8'b0, DivRecip[39:24]};
      default:     op_b = '0;
    endcase

    case (ctl.acc)
      ACC_LOAD:  acc_nxt = {33'b0, prod_r};
      ACC_ADD24: acc_nxt = acc_r + ({33'b0, prod_r} << 24);
      ACC_ADD32: acc_nxt = acc_r + ({33'b0, prod_r} << 32);
      ACC_ADD56: acc_nxt = acc_r + ({33'b0, prod_r} << 56);
      default:   acc_nxt = acc_r;
    endcase
  end

  // Reverse-rotation detection on the captured item
  always_comb begin
    rev_fwd = (ref_r > OneQ16) && (fb_r < -RevThresh);
    rev_bwd = (ref_r < -OneQ16) && (fb_r > RevThresh);
    fb_big  = (fb_r > CtrlThresh) || (fb_r < -CtrlThresh);
    no_pen  = !(rev_fwd || rev_bwd);
    cnt_inc = (cnt_r == CntMax) ? cnt_r : cnt_r + 16'd1;
  end

  always_comb begin
    // round 2*pi*ref back to Q16.16, ties toward +inf
    prod_signed = ref_r[31] ? -$signed({1'b0, acc_r[63:0]}) : $signed({1'b0, acc_r[63:0]});
    prod_rnd    = prod_signed + 65'sd268435456;
    err_round   = 48'($signed(prod_rnd[64:29])) - 48'(fb_r);

    pen_x100 = ({7'b0, pen_cnt_r} << 6) + ({7'b0, pen_cnt_r} << 5) + ({7'b0, pen_cnt_r} << 2);
    pen_amt  = $signed({9'b0, pen_x100, 16'b0});
    // error stays well inside 2^40 here, no saturation needed
    err_pen  = pen_sub_r ? (err_r - pen_amt) : (err_r + pen_amt);

    sum_sat = sat47(49'(err_r) + 49'(integ_r));

    // gain product: drop 16 fraction bits, saturate, restore sign
    gain_raw  = acc_r[70:16];
    gain_mag  = (gain_raw > 55'(Sat47)) ? Sat47[46:0] : gain_raw[46:0];
    gain_term = neg_r ? -$signed({1'b0, gain_mag}) : $signed({1'b0, gain_mag});

    lim48 = $signed({17'b0, output_limit});
    if (unc_r > lim48) begin
      drive48    = lim48;
      clamp_code = CLAMP_HIGH;
    end else if (unc_r < -lim48) begin
      drive48    = -lim48;
      clamp_code = CLAMP_LOW;
    end else begin
      drive48    = unc_r;
      clamp_code = CLAMP_NONE;
    end
    clamp_drive = drive48[31:0];

    diff_sat = sat47(49'(drive_r) - 49'(unc_r));

    // quotient estimate is at most one low; the true remainder fits 11 bits
    q_x1000 = (q_r[10:0] << 10) - (q_r[10:0] << 4) - (q_r[10:0] << 3);
    rem     = mag_r[10:0] - q_x1000;

    q_signed = neg_r ? -$signed({9'b0, q_r}) : $signed({9'b0, q_r});
  end

  always_comb begin
    integ_nxt = integ_r;
    cnt_nxt   = cnt_r;
    case (ctl.alu)
      ALU_ROUND: cnt_nxt = ((rev_fwd || rev_bwd) && !fb_big) ? cnt_inc : '0;
      ALU_INTEG: integ_nxt = sat47(49'(integ_r) + q_signed);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      cnt_r   <= '0;
    end else begin
      integ_r <= integ_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ref_r <= ref_speed_hz;
      fb_r  <= feedback_rad_s;
    end
    prod_r <= {24'b0, op_a} * {32'b0, op_b};
    acc_r  <= acc_nxt;
    case (ctl.alu)
      ALU_ROUND: begin
        err_r     <= err_round;
        pen_cnt_r <= cnt_inc;
        pen_sub_r <= rev_fwd;
      end
      ALU_PEN: err_r <= err_pen;
      ALU_SUM: begin
        mag_r <= mag49(49'(sum_sat));
        neg_r <= sum_sat[47];
      end
      ALU_UNC:   unc_r <= gain_term;
      ALU_CLAMP: drive_r <= clamp_drive;
      ALU_DIFF: begin
        mag_r <= mag49(49'(diff_sat));
        neg_r <= diff_sat[47];
      end
      ALU_BC: begin
        inc_r <= 49'(gain_term);
        mag_r <= mag49(49'(err_r));
        neg_r <= err_r[47];
      end
      ALU_KI: inc_r <= inc_r + 49'(gain_term);
      ALU_DIVPREP: begin
        mag_r <= mag49(inc_r) + RoundHalf;
        neg_r <= inc_r[48];
      end
      ALU_QUOT: q_r <= acc_r[88:49];
      ALU_FIX: begin
        if (rem >= DivBy) begin
          q_r <= q_r + 40'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/speed_pi_backcalc_antiwindup_unit.sv =====
// Channel  Direction  Handshake         Payload
// in       input      in_valid/in_stall in_ref_speed_hz, in_feedback_rad_s
// out      output     out_valid/out_stall out_drive_out, out_clamp_state
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item at a time: the control store walks one shared 32x24 multiplier through
// the 2*pi, three gain and divide-by-1000 products, skipping the penalty step when
// no reverse-rotation penalty applies. The result is registered at step 10; the
// program holds there while an earlier result is still stalled. Reset clears the
// integrator, penalty counter, gains and output limit.
module speed_pi_backcalc_antiwindup_unit
  import spbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_ref_speed_hz,
  input  logic signed [31:0] in_feedback_rad_s,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive_out,
  output logic [1:0]         out_clamp_state,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  seq_state_t         state_r;
  seq_state_t         state_nxt;
  logic [StepW-1:0]   step_r;
  logic [StepW-1:0]   step_nxt;
  uword_t             uw;
  uword_t             ctl;
  logic               go;
  logic               in_accept;
  logic               no_pen;
  logic signed [31:0] clamp_drive;
  clamp_t             clamp_code;

  logic [23:0]        prop_gain_r;
  logic [23:0]        integ_gain_r;
  logic [23:0]        backcalc_gain_r;
  logic [30:0]        output_limit_r;

  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic [1:0]         out_state_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_drive_out   = out_drive_r;
  assign out_clamp_state = out_state_r;

  always_comb begin
    uw        = ucode(step_r);
    go        = !((uw.nx == NX_WAIT_OUT) && out_valid_r && out_stall);
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl       = UopNop;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (go) begin
          ctl = uw;
        end
        case (uw.nx)
          NX_NEXT:     step_nxt = step_r + 1'b1;
          NX_SKIP_PEN: step_nxt = no_pen ? uw.target : step_r + 1'b1;
          NX_WAIT_OUT: step_nxt = go ? step_r + 1'b1 : step_r;
          NX_END: begin
            state_nxt = ST_IDLE;
            step_nxt  = '0;
          end
          default: step_nxt = step_r + 1'b1;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= '0;
      integ_gain_r    <= '0;
      backcalc_gain_r <= '0;
      output_limit_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:     prop_gain_r     <= cfg_data[23:0];
        REG_INTEG_GAIN:    integ_gain_r    <= cfg_data[23:0];
        REG_BACKCALC_GAIN: backcalc_gain_r <= cfg_data[23:0];
        REG_OUTPUT_LIMIT:  output_limit_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Output slot: load on the clamp step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.alu == ALU_CLAMP) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.alu == ALU_CLAMP) begin
      out_drive_r <= clamp_drive;
      out_state_r <= clamp_code;
    end
  end

  spbc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_accept),
    .ref_speed_hz   (in_ref_speed_hz),
    .feedback_rad_s (in_feedback_rad_s),
    .prop_gain      (prop_gain_r),
    .integ_gain     (integ_gain_r),
    .backcalc_gain  (backcalc_gain_r),
    .output_limit   (output_limit_r),
    .ctl            (ctl),
    .no_pen         (no_pen),
    .clamp_drive    (clamp_drive),
    .clamp_code     (clamp_code)
  );

endmodule
